// File: hdl/assert_macros.svh
// assertion macros shared by the sorted predecessor lookup rtl
// depends on nothing; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// File: hdl/spl_pkg.sv
// types, codes and sizes for the sorted predecessor lookup
// depends on nothing; used by every module of the block
package spl_pkg;

    localparam int YEAR_W          = 16;
    localparam int MONTH_W         = 4;
    localparam int KEY_W           = YEAR_W + MONTH_W;
    localparam int ENTRIES_DEFAULT = 1024;

    // input opcodes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_MATCH = 2'd0,
        ST_PRED  = 2'd1,
        ST_NONE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // operations carried along the cell chain
    typedef enum logic [2:0] {
        TOK_NONE,
        TOK_CLEAR,
        TOK_INSERT,
        TOK_QUERY,
        TOK_DROP
    } tok_op_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [YEAR_W-1:0]    key_year;
        logic [MONTH_W-1:0]   key_month;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [YEAR_W-1:0]    found_year;
        logic [MONTH_W-1:0]   found_month;
    } out_item_t;

    // token handed from cell to cell; query accumulators ride along
    typedef struct packed {
        tok_op_t              op;
        logic [KEY_W-1:0]     key;
        logic                 hit;
        logic                 have_below;
        logic [KEY_W-1:0]     below;
    } token_t;

endpackage

// File: hdl/spl_head.sv
// head of the chain: occupancy count and conversion of input items to tokens
// depends on spl_pkg and assert_macros.svh
`include "assert_macros.svh"

module spl_head #(
    parameter int ENTRIES = spl_pkg::ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  spl_pkg::in_item_t item,
    output spl_pkg::token_t   tok
);

    localparam int CountW = $clog2(ENTRIES + 1);
    localparam logic [CountW-1:0] FullCount = CountW'(ENTRIES);

    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              full;

    assign full = (count_reg == FullCount);

    // token formation and count update
    always_comb
    begin
        tok            = '0;
        tok.op         = spl_pkg::TOK_NONE;
        tok.key        = {item.key_year, item.key_month};
        tok.hit        = 1'b0;
        tok.have_below = 1'b0;
        tok.below      = '0;
        count_next     = count_reg;
        if (take)
        begin
            case (item.opcode)
                spl_pkg::OP_CLEAR:
                begin
                    tok.op     = spl_pkg::TOK_CLEAR;
                    count_next = '0;
                end
                spl_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        tok.op = spl_pkg::TOK_DROP;
                    end
                    else
                    begin
                        tok.op     = spl_pkg::TOK_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                spl_pkg::OP_QUERY:
                begin
                    tok.op = spl_pkg::TOK_QUERY;
                end
                default:
                begin
                    tok.op = spl_pkg::TOK_NONE;
                end
            endcase
        end
    end

    // occupancy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= FullCount)
    `ASSERT_NEXT(a_full_holds, clk, rst_n, take && item.opcode == spl_pkg::OP_INSERT && full, count_reg == FullCount)

endmodule

// File: hdl/spl_cell.sv
// one cell of the sorted chain: a stored key and a token stage
// depends on spl_pkg
module spl_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  spl_pkg::token_t tok_in,
    output spl_pkg::token_t tok_out
);

    logic [spl_pkg::KEY_W-1:0] key_reg;
    logic [spl_pkg::KEY_W-1:0] key_next;
    logic                      valid_reg;
    logic                      valid_next;
    spl_pkg::token_t           tok_reg;
    spl_pkg::token_t           tok_next;

    // cell action on the arriving token
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        case (tok_in.op)
            spl_pkg::TOK_CLEAR:
            begin
                valid_next = 1'b0;
            end
            spl_pkg::TOK_INSERT:
            begin
                if (!valid_reg)
                begin
                    // key lands in the first empty cell
                    key_next    = tok_in.key;
                    valid_next  = 1'b1;
                    tok_next.op = spl_pkg::TOK_NONE;
                end
                else if (key_reg > tok_in.key)
                begin
                    // keep the smaller key, push the larger one on
                    key_next     = tok_in.key;
                    tok_next.key = key_reg;
                end
            end
            spl_pkg::TOK_QUERY:
            begin
                if (valid_reg)
                begin
                    if (key_reg == tok_in.key)
                    begin
                        tok_next.hit = 1'b1;
                    end
                    if (key_reg < tok_in.key)
                    begin
                        tok_next.have_below = 1'b1;
                        tok_next.below      = key_reg;
                    end
                end
            end
            default:
            begin
                tok_next = tok_in;
            end
        endcase
    end

    // stored key, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= key_next;
        end
    end

    // control state and token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '{op: spl_pkg::TOK_NONE, key: '0, hit: 1'b0,
                           have_below: 1'b0, below: '0};
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: hdl/sorted_predecessor_lookup.sv
// Sorted multiset of (year, month) keys with predecessor search, built as a
// chain of ENTRIES cells behind an occupancy counter and ahead of one output
// register. Every item enters the chain as a token and moves one cell per
// cycle: an insert settles into place by swapping down, a query collects the
// exact-match flag and the greatest smaller key on its way, a clear empties
// each cell as it passes. One item is accepted per cycle when the output side
// keeps up; a result is formed from the token leaving the last of the ENTRIES
// cells and held in the output register. A full output register that is not
// taken stalls the whole chain and input. No clearing pass follows reset.
// depends on spl_pkg, spl_head, spl_cell and assert_macros.svh
`include "assert_macros.svh"

module sorted_predecessor_lookup #(
    parameter int ENTRIES = spl_pkg::ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spl_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output spl_pkg::out_item_t out_data
);

    logic               adv;
    logic               take;
    spl_pkg::token_t    chain [0:ENTRIES];
    spl_pkg::token_t    last;
    logic               out_valid_reg;
    logic               out_valid_next;
    spl_pkg::out_item_t out_data_reg;
    spl_pkg::out_item_t out_data_next;
    logic               out_no_pred;
    logic               out_found_zero;

    // global advance: the chain moves whenever the output register can load
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign take     = in_valid && adv;

    spl_head #(
        .ENTRIES (ENTRIES)
    ) u_head (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .tok   (chain[0])
    );

    // cell chain
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        spl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last = chain[ENTRIES];

    // result formation from the token leaving the chain
    always_comb
    begin
        out_data_next             = '0;
        out_data_next.status      = spl_pkg::ST_NONE;
        out_data_next.found_year  = '0;
        out_data_next.found_month = '0;
        out_valid_next            = out_valid_reg && !out_ready;
        case (last.op)
            spl_pkg::TOK_DROP:
            begin
                out_data_next.status = spl_pkg::ST_FULL;
                out_valid_next       = 1'b1;
            end
            spl_pkg::TOK_QUERY:
            begin
                out_valid_next = 1'b1;
                if (last.hit)
                begin
                    out_data_next.status = spl_pkg::ST_MATCH;
                end
                else if (last.have_below)
                begin
                    out_data_next.status      = spl_pkg::ST_PRED;
                    out_data_next.found_year  = last.below[spl_pkg::KEY_W-1:spl_pkg::MONTH_W];
                    out_data_next.found_month = last.below[spl_pkg::MONTH_W-1:0];
                end
                else
                begin
                    out_data_next.status = spl_pkg::ST_NONE;
                end
            end
            default:
            begin
                out_data_next = out_data_reg;
            end
        endcase
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // terms for the result field check
    assign out_no_pred    = out_valid_reg && out_data_reg.status != spl_pkg::ST_PRED;
    assign out_found_zero = out_data_reg.found_year == '0 && out_data_reg.found_month == '0;

    `ASSERT_IMPLY(a_no_insert_overflow, clk, rst_n, adv, last.op != spl_pkg::TOK_INSERT)
    `ASSERT_NEXT(a_stall_holds_chain, clk, rst_n, !adv, $stable(last))
    `ASSERT_IMPLY(a_found_zero, clk, rst_n, out_no_pred, out_found_zero)

endmodule

// File: tb/sv/sorted_predecessor_lookup_test.sv
// testbench for sorted_predecessor_lookup: directed, full-set and random item streams,
// each result checked against a sorted-queue predictor of the key set
// depends on spl_pkg and sorted_predecessor_lookup
`timescale 1ns / 1ps

module sorted_predecessor_lookup_test;

    localparam int SET_DEPTH      = spl_pkg::ENTRIES_DEFAULT;
    localparam int DRAIN_CYCLES   = SET_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 10 * (SET_DEPTH + 1);
    localparam int MIX_ITEMS      = 40;
    localparam int PRINT_LIMIT    = 50;
    localparam logic [1:0] OPCODE_UNUSED = 2'b11;

    typedef logic [spl_pkg::KEY_W-1:0] set_key_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    spl_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    spl_pkg::out_item_t out_data;

    // predictor state: the stored keys in ascending order
    set_key_t           key_set[$];
    spl_pkg::out_item_t pending_results[$];
    int                 mismatch_count;
    int                 quiet_cycles;
    bit                 no_stall;

    sorted_predecessor_lookup #(
        .ENTRIES(SET_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(string what);
        mismatch_count++;
        // keep the log short if the block is badly broken
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic spl_pkg::in_item_t make_item(logic [1:0] code, set_key_t key);
        spl_pkg::in_item_t item;
        item = {code, key};
        return item;
    endfunction

    // keys crowd into a few low years half the time, so duplicates and neighbors occur
    function automatic set_key_t random_key();
        if ($urandom_range(1) == 1)
            return {16'($urandom_range(1, 6)), 4'($urandom_range(15))};
        return 20'($urandom);
    endfunction

    // query keys: a stored key, one step off a stored key, or anything
    function automatic set_key_t pick_query_key();
        set_key_t key;
        if (key_set.size() > 0 && $urandom_range(99) < 50)
        begin
            key = key_set[$urandom_range(key_set.size() - 1)];
            case ($urandom_range(2))
                1: key = key + 1'b1;
                2: key = key - 1'b1;
                default: ;
            endcase
            return key;
        end
        return random_key();
    endfunction

    // appends one result to the expected queue
    task automatic add_expected(spl_pkg::out_item_t result);
        pending_results = {pending_results, result};
    endtask

    // predictor: applies one accepted item to the key set, queues any result
    task automatic apply_to_key_set(spl_pkg::in_item_t item);
        set_key_t           key;
        set_key_t           below;
        spl_pkg::out_item_t result;
        int                 pos;
        bit                 hit;
        bit                 have_below;
        key    = {item.key_year, item.key_month};
        result = '0;
        case (item.opcode)
            spl_pkg::OP_CLEAR:
                key_set.delete();
            spl_pkg::OP_INSERT:
            begin
                if (key_set.size() >= SET_DEPTH)
                begin
                    result.status = spl_pkg::ST_FULL;
                    add_expected(result);
                end
                else
                begin
                    // place after any equal keys
                    pos = key_set.size();
                    while (pos > 0 && key_set[pos - 1] > key)
                        pos--;
                    key_set.insert(pos, key);
                end
            end
            spl_pkg::OP_QUERY:
            begin
                hit        = 1'b0;
                have_below = 1'b0;
                below      = '0;
                foreach (key_set[i])
                begin
                    if (key_set[i] == key)
                        hit = 1'b1;
                    else if (key_set[i] < key)
                    begin
                        have_below = 1'b1;
                        below      = key_set[i];
                    end
                end
                if (hit)
                    result.status = spl_pkg::ST_MATCH;
                else if (have_below)
                begin
                    result.status      = spl_pkg::ST_PRED;
                    result.found_year  = below[spl_pkg::KEY_W-1:spl_pkg::MONTH_W];
                    result.found_month = below[spl_pkg::MONTH_W-1:0];
                end
                else
                    result.status = spl_pkg::ST_NONE;
                add_expected(result);
            end
            default: ;
        endcase
    endtask

    // one input transfer; valid stays up after acceptance until the next call decides
    task automatic send_item(spl_pkg::in_item_t item);
        @(negedge clk);
        while (!no_stall && $urandom_range(99) < 26)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do
            @(posedge clk);
        while (!in_ready);
        apply_to_key_set(item);
    endtask

    task automatic check_result(spl_pkg::out_item_t got);
        spl_pkg::out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, status %0d", got.status));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.found_year !== want.found_year)
            report_mismatch($sformatf("found_year %0d, expected %0d",
                                      got.found_year, want.found_year));
        if (got.found_month !== want.found_month)
            report_mismatch($sformatf("found_month %0d, expected %0d",
                                      got.found_month, want.found_month));
    endtask

    // result side: random back-pressure, checks every output transfer
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = no_stall || ($urandom_range(99) >= 26);
            @(posedge clk);
            if (out_valid && out_ready)
                check_result(out_data);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // extremes of every field, duplicates, year zero, the match, predecessor and none statuses and the unused opcode
    task automatic test_directed();
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd100, 4'd6}));
        send_item(make_item(spl_pkg::OP_CLEAR,  '0));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'hFFFF, 4'hF}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'd1, 4'd0}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'hFFFF, 4'hF}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'd0, 4'd0}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'd100, 4'd6}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'd100, 4'd6}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd100, 4'd6}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd100, 4'd7}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd100, 4'd5}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd0, 4'd0}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'd0, 4'd1}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'hFFFF, 4'hF}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'hFFFF, 4'hE}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'h5555, 4'hA}));
        send_item(make_item(OPCODE_UNUSED,      {16'hAAAA, 4'h5}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'hAAAA, 4'h5}));
        send_item(make_item(spl_pkg::OP_CLEAR,  {16'hFFFF, 4'hF}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'hFFFF, 4'hF}));
        send_item(make_item(spl_pkg::OP_INSERT, {16'h8000, 4'h8}));
        send_item(make_item(spl_pkg::OP_QUERY,  {16'h8000, 4'h9}));
    endtask

    // fill to capacity, query the full set, then overflow and recover
    task automatic test_full_set();
        send_item(make_item(spl_pkg::OP_CLEAR, '0));
        no_stall = 1'b1;
        for (int i = 0; i < SET_DEPTH; i++)
        begin
            if (i == SET_DEPTH / 2)
                no_stall = 1'b0;
            send_item(make_item(spl_pkg::OP_INSERT, random_key()));
        end
        send_item(make_item(spl_pkg::OP_QUERY, {16'd0, 4'd0}));
        send_item(make_item(spl_pkg::OP_QUERY, {16'hFFFF, 4'hF}));
        for (int i = 0; i < 40; i++)
            send_item(make_item(spl_pkg::OP_QUERY, pick_query_key()));
        for (int i = 0; i < 8; i++)
        begin
            send_item(make_item(spl_pkg::OP_INSERT, random_key()));
            send_item(make_item(spl_pkg::OP_QUERY, pick_query_key()));
        end
        send_item(make_item(spl_pkg::OP_CLEAR, '0));
        send_item(make_item(spl_pkg::OP_INSERT, {16'd7, 4'd3}));
        send_item(make_item(spl_pkg::OP_QUERY, {16'd7, 4'd4}));
    endtask

    // runs of inserts and queries on small sets, with stray clears and unused opcodes
    task automatic test_random_mix();
        int sent;
        int run_len;
        int pick;
        sent = 0;
        while (sent < MIX_ITEMS)
        begin
            send_item(make_item(spl_pkg::OP_CLEAR, random_key()));
            run_len = $urandom_range(1, 80);
            for (int i = 0; i < run_len; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_item(make_item(spl_pkg::OP_INSERT, random_key()));
                else if (pick < 90)
                    send_item(make_item(spl_pkg::OP_QUERY, pick_query_key()));
                else if (pick < 95)
                    send_item(make_item(OPCODE_UNUSED, random_key()));
                else
                    send_item(make_item(spl_pkg::OP_CLEAR, random_key()));
            end
            sent += run_len + 1;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        no_stall       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix();
        test_full_set();
        test_random_mix();

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
